// ----- src/ewald_short_range_pair_force_defines.svh -----
// assertion macros for the short-range pair force block
// used by the files that check their own logic, needs i_clk and i_rst_n in scope
`ifndef EWALD_SHORT_RANGE_PAIR_FORCE_DEFINES_SVH
`define EWALD_SHORT_RANGE_PAIR_FORCE_DEFINES_SVH

// clocking and reset qualifier shared by all checks
`define ESR_CLK_RST @(posedge i_clk) disable iff (!i_rst_n)

// concurrent check with a message
`define ESR_ASSERT(label, prop, msg) \
    label: assert property (`ESR_CLK_RST prop) else $error(msg);

`endif

// ----- src/esr_pkg.sv -----
// shared types, constants and fixed-point helpers of the pair force block
// no dependencies
package esr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int Q_DEPTH     = 4;
    localparam int QP_W        = $clog2(Q_DEPTH);

    localparam logic [IDX_W-1:0] K_MAX = IDX_W'(TABLE_DEPTH - 3);

    localparam logic signed [47:0] MAX47 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN47 = 48'sh8000_0000_0000;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [15:0] HALF_Q16  = 16'd32768;
    localparam logic [15:0] SIXTH_Q16 = 16'd10923;

    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam logic [2:0] CFG_BOX_LOW_X  = 3'd0;
    localparam logic [2:0] CFG_BOX_HIGH_X = 3'd1;
    localparam logic [2:0] CFG_BOX_LOW_Y  = 3'd2;
    localparam logic [2:0] CFG_BOX_HIGH_Y = 3'd3;
    localparam logic [2:0] CFG_BOX_LOW_Z  = 3'd4;
    localparam logic [2:0] CFG_BOX_HIGH_Z = 3'd5;
    localparam logic [2:0] CFG_CUTOFF_SQ  = 3'd6;
    localparam logic [2:0] CFG_INV_SPC_SQ = 3'd7;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_NEIGH  = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef logic signed [49:0] t_opnd;

    typedef struct packed {
        t_op                op;
        logic [9:0]         index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] charge;
        logic signed [31:0] force_word;
        logic signed [31:0] energy_word;
    } t_item;

    typedef struct packed {
        logic signed [31:0] box_low_x;
        logic signed [31:0] box_high_x;
        logic signed [31:0] box_low_y;
        logic signed [31:0] box_high_y;
        logic signed [31:0] box_low_z;
        logic signed [31:0] box_high_z;
        logic [47:0]        cutoff_sq;
        logic [31:0]        inv_spc_sq;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [9:0]         particle_id;
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] energy;
        logic signed [47:0] virial;
    } t_result;

    typedef struct packed {
        logic  start;
        t_opnd a;
        t_opnd b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [47:0] q;
        logic [95:0]        prod;
    } t_mul_rsp;

    // clamp a wide signed sum to 48 bits
    function automatic logic signed [47:0] sat48(input t_opnd v);
        logic signed [47:0] r;
        if (v > t_opnd'(MAX47)) r = MAX47;
        else if (v < t_opnd'(MIN47)) r = MIN47;
        else r = v[47:0];
        return r;
    endfunction

    // floor(product / 2^16) from magnitude product and sign, saturated
    function automatic logic signed [47:0] mulq_fin(input logic [95:0] p, input logic neg);
        logic [47:0]        q;
        logic [48:0]        qn;
        logic signed [47:0] r;
        q  = p[63:16];
        qn = {1'b0, q} + 49'(|p[15:0]);
        if (|p[95:64]) r = neg ? MIN47 : MAX47;
        else if (!neg) r = q[47] ? MAX47 : q;
        else if (qn > 49'h1_0000_0000_0000 >> 1) r = MIN47;
        else r = 48'(-qn);
        return r;
    endfunction

endpackage

// ----- src/esr_front.sv -----
// front end: takes stream words, decodes the mode and queues the items
// depends on esr_pkg and ewald_short_range_pair_force_defines.svh
module esr_front import esr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // index, pos_x, pos_y, pos_z, charge, force word, energy word
    input  logic [1:0]   s_axis_tuser,  // mode
    input  logic         i_pop,
    output logic         o_q_valid,
    output t_item        o_q_item
);
    `include "ewald_short_range_pair_force_defines.svh"

    t_item          r_q [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QP_W:0]   r_count;
    logic           push;
    t_item          item;

    always_comb begin
        item.op          = t_op'(s_axis_tuser);
        item.index       = s_axis_tdata[9:0];
        item.pos_x       = s_axis_tdata[41:10];
        item.pos_y       = s_axis_tdata[73:42];
        item.pos_z       = s_axis_tdata[105:74];
        item.charge      = s_axis_tdata[121:106];
        item.force_word  = s_axis_tdata[153:122];
        item.energy_word = s_axis_tdata[185:154];
    end

    assign s_axis_tready = (r_count != (QP_W+1)'(Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != '0);
    assign o_q_item      = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr_ptr] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (QP_W+1)'(push) - (QP_W+1)'(i_pop);
        end
    end

    `ESR_ASSERT(a_no_underflow, i_pop |-> r_count != '0, "queue popped while empty")
    `ESR_ASSERT(a_count_range, r_count <= (QP_W+1)'(Q_DEPTH), "queue count out of range")
    `ESR_ASSERT(a_full_stall, r_count == (QP_W+1)'(Q_DEPTH) && !i_pop |=> !$past(push),
        "word taken while queue full")

endmodule

// ----- src/esr_mul.sv -----
// shared iterative multiplier: 48x48 magnitude product in four 24x24 steps
// depends on esr_pkg
module esr_mul import esr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} t_mstate;

    t_mstate            r_state;
    logic [47:0]        r_ma, r_mb;
    logic               r_neg, r_done;
    logic [1:0]         r_cnt;
    logic [95:0]        r_acc, r_prod;
    logic signed [47:0] r_q;
    t_opnd              abs_a, abs_b;
    logic [23:0]        pa, pb;
    logic [47:0]        pp;
    logic [95:0]        pp_sh;

    assign abs_a = i_req.a[49] ? -i_req.a : i_req.a;
    assign abs_b = i_req.b[49] ? -i_req.b : i_req.b;
    assign pa    = r_cnt[0] ? r_ma[47:24] : r_ma[23:0];
    assign pb    = r_cnt[1] ? r_mb[47:24] : r_mb[23:0];
    assign pp    = pa * pb;

    always_comb begin
        unique case (r_cnt)
            2'd0:    pp_sh = 96'(pp);
            2'd3:    pp_sh = 96'(pp) << 48;
            default: pp_sh = 96'(pp) << 24;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_ma    <= abs_a[47:0];
                        r_mb    <= abs_b[47:0];
                        r_neg   <= i_req.a[49] ^ i_req.b[49];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd3) r_state <= M_FIN;
                end
                M_FIN: begin
                    r_q     <= mulq_fin(r_acc, r_neg);
                    r_prod  <= r_acc;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != M_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.prod = r_prod;

endmodule

// ----- src/esr_back.sv -----
// back end: tables, particle state, pair sequencer and output register
// depends on esr_pkg and ewald_short_range_pair_force_defines.svh, and drives the multiplier
module esr_back import esr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_q_valid,
    input  t_item    i_q_item,
    output logic     o_pop,
    output t_mul_req o_mul_req,
    input  t_mul_rsp i_mul_rsp,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res
);
    `include "ewald_short_range_pair_force_defines.svh"

    typedef enum logic [2:0] {ST_IDLE, ST_WRAP, ST_MUL, ST_WAIT, ST_RD, ST_EMIT} t_state;
    typedef enum logic [3:0] {
        SP_SQX, SP_SQY, SP_SQZ, SP_IDX, SP_T1, SP_T2, SP_T3, SP_T4, SP_QQ,
        SP_S6, SP_VIR, SP_FX, SP_FY, SP_FZ
    } t_step;

    t_state             r_state;
    t_step              r_step;
    logic [63:0]        r_tab [TABLE_DEPTH];
    logic [63:0]        r_tab_q;
    logic [IDX_W-1:0]   rd_addr;
    logic signed [31:0] r_own_x, r_own_y, r_own_z;
    logic signed [15:0] r_own_q;
    logic [9:0]         r_own_id;
    logic signed [47:0] r_sfx, r_sfy, r_sfz, r_sen, r_svir;
    t_item              r_cur;
    logic signed [34:0] r_d [3];
    logic signed [31:0] r_qq;
    logic [49:0]        r_rsq_acc;
    logic               r_big;
    logic [47:0]        r_rsq;
    logic [IDX_W-1:0]   r_k;
    logic [15:0]        r_fr;
    logic [1:0]         r_rdcnt;
    logic signed [31:0] r_vf [3];
    logic signed [31:0] r_ve [3];
    logic               r_tsel;
    logic signed [47:0] r_t1, r_t2, r_m, r_ip, r_fm, r_en, r_s6, r_vir, r_fx, r_fy;
    t_result            r_res, r_out;
    logic               r_ovalid;

    // wrapped displacement per axis
    logic signed [33:0] raw_d [3];
    logic signed [33:0] box_lo [3], box_hi [3], box_len [3];
    logic signed [34:0] wrap_d [3];

    always_comb begin
        raw_d[0]  = 34'(r_own_x) - 34'(r_cur.pos_x);
        raw_d[1]  = 34'(r_own_y) - 34'(r_cur.pos_y);
        raw_d[2]  = 34'(r_own_z) - 34'(r_cur.pos_z);
        box_lo[0] = 34'(i_cfg.box_low_x);
        box_hi[0] = 34'(i_cfg.box_high_x);
        box_lo[1] = 34'(i_cfg.box_low_y);
        box_hi[1] = 34'(i_cfg.box_high_y);
        box_lo[2] = 34'(i_cfg.box_low_z);
        box_hi[2] = 34'(i_cfg.box_high_z);
        for (int a = 0; a < 3; a++) begin
            box_len[a] = box_hi[a] - box_lo[a];
            if (raw_d[a] >= box_hi[a]) wrap_d[a] = 35'(raw_d[a]) - 35'(box_len[a]);
            else if (raw_d[a] < box_lo[a]) wrap_d[a] = 35'(raw_d[a]) + 35'(box_len[a]);
            else wrap_d[a] = 35'(raw_d[a]);
        end
    end

    // interpolation operands of the selected table
    logic signed [31:0] v0, v1, v2;
    assign v0 = r_tsel ? r_ve[0] : r_vf[0];
    assign v1 = r_tsel ? r_ve[1] : r_vf[1];
    assign v2 = r_tsel ? r_ve[2] : r_vf[2];

    always_comb begin
        o_mul_req.start = (r_state == ST_MUL);
        unique case (r_step)
            SP_SQX: begin o_mul_req.a = t_opnd'(r_d[0]); o_mul_req.b = t_opnd'(r_d[0]); end
            SP_SQY: begin o_mul_req.a = t_opnd'(r_d[1]); o_mul_req.b = t_opnd'(r_d[1]); end
            SP_SQZ: begin o_mul_req.a = t_opnd'(r_d[2]); o_mul_req.b = t_opnd'(r_d[2]); end
            SP_IDX: begin
                o_mul_req.a = t_opnd'(r_rsq);
                o_mul_req.b = t_opnd'(i_cfg.inv_spc_sq);
            end
            SP_T1: begin
                o_mul_req.a = t_opnd'(v1) - t_opnd'(v0);
                o_mul_req.b = t_opnd'(r_fr);
            end
            SP_T2: begin
                o_mul_req.a = t_opnd'(v2) - t_opnd'(v1);
                o_mul_req.b = t_opnd'(r_fr) - t_opnd'(ONE_Q16);
            end
            SP_T3: begin
                o_mul_req.a = t_opnd'(r_t2) - t_opnd'(r_t1);
                o_mul_req.b = t_opnd'(r_fr);
            end
            SP_T4:  begin o_mul_req.a = t_opnd'(r_m);  o_mul_req.b = t_opnd'(HALF_Q16); end
            SP_QQ:  begin o_mul_req.a = t_opnd'(r_qq); o_mul_req.b = t_opnd'(r_ip); end
            SP_S6:  begin o_mul_req.a = t_opnd'(SIXTH_Q16); o_mul_req.b = t_opnd'(r_rsq); end
            SP_VIR: begin o_mul_req.a = t_opnd'(r_s6); o_mul_req.b = t_opnd'(r_fm); end
            SP_FX:  begin o_mul_req.a = t_opnd'(r_d[0]); o_mul_req.b = t_opnd'(r_fm); end
            SP_FY:  begin o_mul_req.a = t_opnd'(r_d[1]); o_mul_req.b = t_opnd'(r_fm); end
            SP_FZ:  begin o_mul_req.a = t_opnd'(r_d[2]); o_mul_req.b = t_opnd'(r_fm); end
            default: begin o_mul_req.a = '0; o_mul_req.b = '0; end
        endcase
    end

    // squared distance close-out and table position
    logic [49:0] n_rsq_acc;
    logic        n_big;
    logic [47:0] n_rsq;
    logic        k_over;
    assign n_rsq_acc = r_rsq_acc + 50'(i_mul_rsp.prod[63:16]);
    assign n_big     = r_big || (|i_mul_rsp.prod[95:64]);
    assign n_rsq     = (n_big || (|n_rsq_acc[49:48])) ? '1 : n_rsq_acc[47:0];
    assign k_over    = (|i_mul_rsp.prod[95:32+IDX_W])
                       || (i_mul_rsp.prod[32+IDX_W-1:32] > K_MAX);

    // table write and read port
    logic             tab_we;
    logic [IDX_W-1:0] tab_wa;
    assign tab_we  = (r_state == ST_IDLE) && i_q_valid && (i_q_item.op == OP_LOAD)
                     && (32'(i_q_item.index) < 32'(TABLE_DEPTH));
    assign tab_wa  = IDX_W'(i_q_item.index);
    assign rd_addr = r_k + IDX_W'(r_rdcnt);

    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab[tab_wa] <= {i_q_item.energy_word, i_q_item.force_word};
        r_tab_q <= r_tab[rd_addr];
    end

    assign o_pop = (r_state == ST_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SP_SQX;
            r_ovalid <= 1'b0;
            r_own_x  <= '0;
            r_own_y  <= '0;
            r_own_z  <= '0;
            r_own_q  <= '0;
            r_own_id <= '0;
            r_sfx    <= '0;
            r_sfy    <= '0;
            r_sfz    <= '0;
            r_sen    <= '0;
            r_svir   <= '0;
            r_rdcnt  <= '0;
            r_tsel   <= 1'b0;
        end else begin
            // the emit state handles its own handshake
            if (r_ovalid && i_ready && r_state != ST_EMIT) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_cur <= i_q_item;
                        unique case (i_q_item.op)
                            OP_LOAD: ;
                            OP_START: begin
                                r_own_x  <= i_q_item.pos_x;
                                r_own_y  <= i_q_item.pos_y;
                                r_own_z  <= i_q_item.pos_z;
                                r_own_q  <= i_q_item.charge;
                                r_own_id <= i_q_item.index;
                                r_sfx    <= '0;
                                r_sfy    <= '0;
                                r_sfz    <= '0;
                                r_sen    <= '0;
                                r_svir   <= '0;
                            end
                            OP_NEIGH: r_state <= ST_WRAP;
                            OP_FINISH: begin
                                r_res   <= '{KIND_TOTAL, r_own_id, r_sfx, r_sfy, r_sfz,
                                             r_sen, r_svir};
                                r_state <= ST_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WRAP: begin
                    for (int a = 0; a < 3; a++) r_d[a] <= wrap_d[a];
                    r_qq      <= r_own_q * r_cur.charge;
                    r_rsq_acc <= '0;
                    r_big     <= 1'b0;
                    r_tsel    <= 1'b0;
                    r_step    <= SP_SQX;
                    r_state   <= ST_MUL;
                end
                ST_MUL: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (i_mul_rsp.done) begin
                        unique case (r_step)
                            SP_SQX: begin
                                r_rsq_acc <= n_rsq_acc;
                                r_big     <= n_big;
                                r_step    <= SP_SQY;
                                r_state   <= ST_MUL;
                            end
                            SP_SQY: begin
                                r_rsq_acc <= n_rsq_acc;
                                r_big     <= n_big;
                                r_step    <= SP_SQZ;
                                r_state   <= ST_MUL;
                            end
                            SP_SQZ: begin
                                r_rsq  <= n_rsq;
                                r_step <= SP_IDX;
                                // out of cutoff: nothing emitted, sums untouched
                                r_state <= (n_rsq >= i_cfg.cutoff_sq) ? ST_IDLE : ST_MUL;
                            end
                            SP_IDX: begin
                                r_k     <= k_over ? K_MAX : i_mul_rsp.prod[32+IDX_W-1:32];
                                r_fr    <= k_over ? '0 : i_mul_rsp.prod[31:16];
                                r_rdcnt <= '0;
                                r_step  <= SP_T1;
                                r_state <= ST_RD;
                            end
                            SP_T1: begin
                                r_t1    <= sat48(t_opnd'(v0) + t_opnd'(i_mul_rsp.q));
                                r_step  <= SP_T2;
                                r_state <= ST_MUL;
                            end
                            SP_T2: begin
                                r_t2    <= sat48(t_opnd'(v1) + t_opnd'(i_mul_rsp.q));
                                r_step  <= SP_T3;
                                r_state <= ST_MUL;
                            end
                            SP_T3: begin
                                r_m     <= i_mul_rsp.q;
                                r_step  <= SP_T4;
                                r_state <= ST_MUL;
                            end
                            SP_T4: begin
                                r_ip    <= sat48(t_opnd'(r_t1) + t_opnd'(i_mul_rsp.q));
                                r_step  <= SP_QQ;
                                r_state <= ST_MUL;
                            end
                            SP_QQ: begin
                                r_state <= ST_MUL;
                                if (!r_tsel) begin
                                    r_fm   <= i_mul_rsp.q;
                                    r_tsel <= 1'b1;
                                    r_step <= SP_T1;
                                end else begin
                                    r_en   <= i_mul_rsp.q;
                                    r_step <= SP_S6;
                                end
                            end
                            SP_S6: begin
                                r_s6    <= i_mul_rsp.q;
                                r_step  <= SP_VIR;
                                r_state <= ST_MUL;
                            end
                            SP_VIR: begin
                                r_vir   <= i_mul_rsp.q;
                                r_step  <= SP_FX;
                                r_state <= ST_MUL;
                            end
                            SP_FX: begin
                                r_fx    <= i_mul_rsp.q;
                                r_step  <= SP_FY;
                                r_state <= ST_MUL;
                            end
                            SP_FY: begin
                                r_fy    <= i_mul_rsp.q;
                                r_step  <= SP_FZ;
                                r_state <= ST_MUL;
                            end
                            SP_FZ: begin
                                r_sfx   <= sat48(t_opnd'(r_sfx) + t_opnd'(r_fx));
                                r_sfy   <= sat48(t_opnd'(r_sfy) + t_opnd'(r_fy));
                                r_sfz   <= sat48(t_opnd'(r_sfz) + t_opnd'(i_mul_rsp.q));
                                r_sen   <= sat48(t_opnd'(r_sen) + t_opnd'(r_en));
                                r_svir  <= sat48(t_opnd'(r_svir) + t_opnd'(r_vir));
                                r_res   <= '{KIND_PAIR, r_cur.index, r_fx, r_fy,
                                             i_mul_rsp.q, r_en, r_vir};
                                r_state <= ST_EMIT;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD: begin
                    // read data arrives in the cycle after its address is set
                    r_rdcnt <= r_rdcnt + 1'b1;
                    if (r_rdcnt != 2'd0) begin
                        r_vf[r_rdcnt - 2'd1] <= r_tab_q[31:0];
                        r_ve[r_rdcnt - 2'd1] <= r_tab_q[63:32];
                    end
                    if (r_rdcnt == 2'd3) r_state <= ST_MUL;
                end
                ST_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_out;

    `ESR_ASSERT(a_start_idle, o_mul_req.start |-> !i_mul_rsp.busy, "multiplier restarted while busy")
    `ESR_ASSERT(a_done_in_wait, i_mul_rsp.done |-> r_state == ST_WAIT,
        "multiplier result arrived outside wait")
    `ESR_ASSERT(a_pop_idle, o_pop |=> r_state != ST_RD && r_state != ST_WAIT,
        "queue pop did not restart the sequencer")

endmodule

// ----- src/ewald_short_range_pair_force.sv -----
// top level of the short-range pair force block: config registers and wiring
// depends on esr_pkg, esr_front, esr_mul, esr_back
//
// Short-range Ewald pair force engine in Q16.16 fixed point. Input words carry
// a mode in tuser: table load, particle start, neighbor, particle finish. Loads
// write one entry of the force and energy tables (1024 entries each); a start
// latches particle i and clears its sums; a neighbor is wrapped once through
// the periodic box, dropped at or beyond the cutoff, otherwise interpolated
// quadratically from three table entries and emitted as a per-pair word
// (kind 0) while also added to saturating sums; a finish emits the sums
// (kind 1). Table entries must be loaded before a neighbor reads them. A
// four-word queue decouples input from the sequencer, and a result register
// decouples the sequencer from the output, so input keeps flowing while a
// result waits. A neighbor runs 19 products one after another through a
// single shared multiplier, each in four 24x24 partial steps plus result
// formatting, plus reads of three table entries. Configuration is written
// through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only while
// idle, which the block itself does not enforce.
module ewald_short_range_pair_force import esr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [47:0]  i_cfg_data,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // index, pos_x, pos_y, pos_z, charge, force word, energy word
    input  logic [1:0]   s_axis_tuser,  // mode
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,  // particle_id, force_x, force_y, force_z, energy, virial
    output logic [0:0]   m_axis_tuser   // kind
);

    t_cfg     r_cfg;
    logic     q_valid, q_pop;
    t_item    q_item;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_result  res;

    // register file, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_LOW_X:  r_cfg.box_low_x  <= i_cfg_data[31:0];
                CFG_BOX_HIGH_X: r_cfg.box_high_x <= i_cfg_data[31:0];
                CFG_BOX_LOW_Y:  r_cfg.box_low_y  <= i_cfg_data[31:0];
                CFG_BOX_HIGH_Y: r_cfg.box_high_y <= i_cfg_data[31:0];
                CFG_BOX_LOW_Z:  r_cfg.box_low_z  <= i_cfg_data[31:0];
                CFG_BOX_HIGH_Z: r_cfg.box_high_z <= i_cfg_data[31:0];
                CFG_CUTOFF_SQ:  r_cfg.cutoff_sq  <= i_cfg_data;
                CFG_INV_SPC_SQ: r_cfg.inv_spc_sq <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // accept and decode, queue of pending items
    esr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (q_pop),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item)
    );

    // shared product unit
    esr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // tables, particle state and pair sequencer
    esr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .o_mul_req (mul_req),
        .i_mul_rsp (mul_rsp),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    // result word packing, lowest field first
    assign m_axis_tdata = {6'd0, res.virial, res.energy, res.force_z, res.force_y,
                           res.force_x, res.particle_id};
    assign m_axis_tuser = res.kind;

endmodule
